[rtl/imu_window_mean_tilt_integrator_core_defines.svh]
// Assertion macros shared by the windowed-mean IMU integrator RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef IMU_WINDOW_MEAN_TILT_INTEGRATOR_CORE_DEFINES_SVH
`define IMU_WINDOW_MEAN_TILT_INTEGRATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define IMWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IMWT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IMWT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IMWT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/imwt_pkg.sv]
// Shared types, constants and arithmetic helpers of the windowed-mean IMU integrator.
// Used by imwt_ctrl, imwt_dp and the top level; depends on nothing else.
`timescale 1ns / 1ps
package imwt_pkg;

    localparam int WINDOW_DEF      = 16;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int NCH             = 7;
    localparam int ACC_W           = 32;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 1'b1;

    localparam logic [CFG_W-1:0] TIME_STEP_RST = 16'd1311;
    localparam logic [CFG_W-1:0] DECAY_RST     = 16'd65208;

    localparam logic [18:0] TWO_PI_Q  = 19'd411775;
    localparam logic [18:0] PI_Q      = 19'd205887;
    localparam logic [18:0] HALF_PI_Q = 19'd102944;

    localparam logic signed [32:0] GRAVITY_Q = 33'sd642908;
    localparam logic signed [23:0] CORDIC_X0 = 24'sd39797;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_SUMS, OP_DIV,
        OP_M_ROLL, OP_A_ROLL, OP_M_PITCH, OP_A_PITCH, OP_M_YAW, OP_A_YAW,
        OP_COS_P, OP_COS_R,
        OP_M_G1, OP_A_G1, OP_M_G2, OP_A_G2,
        OP_M_V1, OP_A_V1, OP_M_V2, OP_A_V2,
        OP_M_DT2, OP_A_DT2, OP_M_P1, OP_A_P1, OP_M_P2, OP_A_P2, OP_M_P3, OP_A_P3,
        OP_PUBLISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cos_done;
        logic out_busy;
    } t_stat;

    // Arctangent of 2^-i in Q16.16.
    function automatic logic signed [23:0] atan_q(logic [3:0] i);
        logic signed [23:0] v;
        case (i)
            4'd0:    v = 24'sd51472;
            4'd1:    v = 24'sd30386;
            4'd2:    v = 24'sd16055;
            4'd3:    v = 24'sd8150;
            4'd4:    v = 24'sd4091;
            4'd5:    v = 24'sd2047;
            4'd6:    v = 24'sd1024;
            4'd7:    v = 24'sd512;
            4'd8:    v = 24'sd256;
            4'd9:    v = 24'sd128;
            4'd10:   v = 24'sd64;
            4'd11:   v = 24'sd32;
            4'd12:   v = 24'sd16;
            4'd13:   v = 24'sd8;
            4'd14:   v = 24'sd4;
            default: v = 24'sd2;
        endcase
        return v;
    endfunction

    // Round half up, then drop s fraction bits (floor shift).
    function automatic logic signed [71:0] rnd72(logic signed [71:0] v, int s);
        return (v + (72'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/imwt_ctrl.sv]
// Sequencing state machine of the windowed-mean IMU integrator.
// Depends on imwt_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "imu_window_mean_tilt_integrator_core_defines.svh"
module imwt_ctrl
    import imwt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_SUMS, ST_DIV,
        ST_M_ROLL, ST_A_ROLL, ST_M_PITCH, ST_A_PITCH, ST_M_YAW, ST_A_YAW,
        ST_COS_P, ST_COS_R,
        ST_M_G1, ST_A_G1, ST_M_G2, ST_A_G2,
        ST_M_V1, ST_A_V1, ST_M_V2, ST_A_V2,
        ST_M_DT2, ST_A_DT2, ST_M_P1, ST_A_P1, ST_M_P2, ST_A_P2, ST_M_P3, ST_A_P3,
        ST_PUBLISH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    n_op;

    always_comb begin
        n_state = r_state;
        n_op    = OP_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_LOAD;
            end
            ST_LOAD:    begin n_op = OP_LOAD;    n_state = ST_SUMS;    end
            ST_SUMS:    begin n_op = OP_SUMS;    n_state = ST_DIV;     end
            ST_DIV: begin
                n_op = OP_DIV;
                if (i_stat.div_done) n_state = ST_M_ROLL;
            end
            ST_M_ROLL:  begin n_op = OP_M_ROLL;  n_state = ST_A_ROLL;  end
            ST_A_ROLL:  begin n_op = OP_A_ROLL;  n_state = ST_M_PITCH; end
            ST_M_PITCH: begin n_op = OP_M_PITCH; n_state = ST_A_PITCH; end
            ST_A_PITCH: begin n_op = OP_A_PITCH; n_state = ST_M_YAW;   end
            ST_M_YAW:   begin n_op = OP_M_YAW;   n_state = ST_A_YAW;   end
            ST_A_YAW:   begin n_op = OP_A_YAW;   n_state = ST_COS_P;   end
            ST_COS_P: begin
                n_op = OP_COS_P;
                if (i_stat.cos_done) n_state = ST_COS_R;
            end
            ST_COS_R: begin
                n_op = OP_COS_R;
                if (i_stat.cos_done) n_state = ST_M_G1;
            end
            ST_M_G1:    begin n_op = OP_M_G1;    n_state = ST_A_G1;    end
            ST_A_G1:    begin n_op = OP_A_G1;    n_state = ST_M_G2;    end
            ST_M_G2:    begin n_op = OP_M_G2;    n_state = ST_A_G2;    end
            ST_A_G2:    begin n_op = OP_A_G2;    n_state = ST_M_V1;    end
            ST_M_V1:    begin n_op = OP_M_V1;    n_state = ST_A_V1;    end
            ST_A_V1:    begin n_op = OP_A_V1;    n_state = ST_M_V2;    end
            ST_M_V2:    begin n_op = OP_M_V2;    n_state = ST_A_V2;    end
            ST_A_V2:    begin n_op = OP_A_V2;    n_state = ST_M_DT2;   end
            ST_M_DT2:   begin n_op = OP_M_DT2;   n_state = ST_A_DT2;   end
            ST_A_DT2:   begin n_op = OP_A_DT2;   n_state = ST_M_P1;    end
            ST_M_P1:    begin n_op = OP_M_P1;    n_state = ST_A_P1;    end
            ST_A_P1:    begin n_op = OP_A_P1;    n_state = ST_M_P2;    end
            ST_M_P2:    begin n_op = OP_M_P2;    n_state = ST_A_P2;    end
            ST_A_P2:    begin n_op = OP_A_P2;    n_state = ST_M_P3;    end
            ST_M_P3:    begin n_op = OP_M_P3;    n_state = ST_A_P3;    end
            ST_A_P3:    begin n_op = OP_A_P3;    n_state = ST_PUBLISH; end
            ST_PUBLISH: begin
                n_op = OP_PUBLISH;
                if (!i_stat.out_busy) n_state = ST_IDLE;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready   = (r_state == ST_IDLE);
    assign o_cmd.op     = n_op;
    assign o_cmd.accept = i_s_tvalid && o_s_tready;

    `IMWT_ASSERT_NXT(a_accept_loads, i_clk, i_rst_n, o_cmd.accept, r_state == ST_LOAD)
    `IMWT_ASSERT_NXT(a_div_holds, i_clk, i_rst_n,
        r_state == ST_DIV && !i_stat.div_done, r_state == ST_DIV)
    `IMWT_ASSERT_NXT(a_publish_ends, i_clk, i_rst_n,
        r_state == ST_PUBLISH && !i_stat.out_busy, r_state == ST_IDLE)

endmodule

[rtl/imwt_dp.sv]
// Datapath of the windowed-mean IMU integrator: sample window, sums, divider,
// CORDIC, shared multiplier, accumulators and output register. Uses imwt_pkg.
`timescale 1ns / 1ps
`include "imu_window_mean_tilt_integrator_core_defines.svh"
module imwt_dp
    import imwt_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_W        = ((NCH * SAMPLE_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((NCH * SAMPLE_BITS + 5 * ACC_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [IN_W-1:0]      i_s_tdata,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [OUT_W-1:0]     o_m_tdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int ROW_W  = NCH * SB;
    localparam int SUM_W  = SB + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int DBIT_W = $clog2(SUM_W + 1);

    logic [ROW_W-1:0] r_mem [WINDOW];
    logic [ROW_W-1:0] r_in;
    logic [ROW_W-1:0] r_old;

    logic signed [SUM_W-1:0] r_sum  [NCH];
    logic signed [SB-1:0]    r_mean [NCH];
    logic [CNT_W-1:0]        r_fill;
    logic [SLOT_W-1:0]       r_slot;
    logic [CFG_W-1:0]        r_dt;
    logic [CFG_W-1:0]        r_decay;

    logic [2:0]        r_dch;
    logic [DBIT_W-1:0] r_dbit;
    logic [SUM_W-1:0]  r_dq;
    logic [CNT_W-1:0]  r_rem;
    logic              r_dneg;
    logic [CNT_W:0]    n_dt;
    logic              n_dge;
    logic [SUM_W-1:0]  n_dq;
    logic              n_div_last;

    logic [4:0]         r_ccnt;
    logic [31:0]        r_red;
    logic               r_aneg;
    logic               r_cneg;
    logic signed [23:0] r_x;
    logic signed [23:0] r_y;
    logic signed [23:0] r_z;
    logic signed [18:0] r_cp;
    logic signed [18:0] r_cr;
    logic signed [31:0] n_ang;
    logic [32:0]        n_cmp;
    logic [18:0]        n_f0;
    logic [18:0]        n_f1;
    logic signed [23:0] n_x;
    logic signed [23:0] n_y;
    logic signed [23:0] n_z;
    logic signed [18:0] n_cos;
    logic               n_cos_op;

    logic signed [32:0] n_a;
    logic signed [18:0] n_b;
    logic signed [51:0] r_prod;
    logic signed [71:0] n_p72;

    logic signed [31:0] r_roll;
    logic signed [31:0] r_pitch;
    logic signed [31:0] r_yaw;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_pos;
    logic signed [32:0] r_g1;
    logic signed [31:0] r_diff;
    logic signed [39:0] r_vtmp;
    logic [31:0]        r_dt2;
    logic signed [67:0] r_pa;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_out;
    logic [OUT_W-1:0]  n_out;
    logic              n_busy;
    logic              n_full;

    assign n_full = (r_fill == CNT_W'(WINDOW));
    assign n_busy = r_ovalid && !i_m_tready;

    // Window memory: read of the slot about to be replaced, then write of the new row.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_in <= i_s_tdata[ROW_W-1:0];
        if (i_cmd.op == OP_LOAD) r_old <= r_mem[r_slot];
        if (i_cmd.op == OP_SUMS) r_mem[r_slot] <= r_in;
    end

    // Restoring divider step on the magnitude.
    assign n_dt       = {r_rem, r_dq[SUM_W-1]};
    assign n_dge      = (n_dt >= {1'b0, r_fill});
    assign n_dq       = {r_dq[SUM_W-2:0], n_dge};
    assign n_div_last = (i_cmd.op == OP_DIV) && (r_dch == 3'(NCH - 1))
                        && (r_dbit == DBIT_W'(SUM_W));

    // Angle reduction, fold and CORDIC.
    assign n_cos_op = (i_cmd.op == OP_COS_P) || (i_cmd.op == OP_COS_R);
    assign n_ang    = (i_cmd.op == OP_COS_P) ? r_pitch : r_roll;
    assign n_cmp    = {14'd0, TWO_PI_Q} << (5'd14 - r_ccnt);

    always_comb begin
        n_f0 = r_red[18:0];
        if (r_aneg && n_f0 != 19'd0) n_f0 = TWO_PI_Q - n_f0;
        if (n_f0 > PI_Q) n_f0 = TWO_PI_Q - n_f0;
        n_f1 = (n_f0 > HALF_PI_Q) ? PI_Q - n_f0 : n_f0;
    end

    always_comb begin
        if (r_z >= 24'sd0) begin
            n_x = r_x - (r_y >>> r_ccnt[3:0]);
            n_y = r_y + (r_x >>> r_ccnt[3:0]);
            n_z = r_z - atan_q(r_ccnt[3:0]);
        end else begin
            n_x = r_x + (r_y >>> r_ccnt[3:0]);
            n_y = r_y - (r_x >>> r_ccnt[3:0]);
            n_z = r_z + atan_q(r_ccnt[3:0]);
        end
        n_cos = r_cneg ? 19'(-n_x) : 19'(n_x);
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        n_a = '0;
        n_b = '0;
        case (i_cmd.op)
            OP_M_ROLL:  begin n_a = 33'(r_mean[4]); n_b = $signed({3'b0, r_dt}); end
            OP_M_PITCH: begin n_a = 33'(r_mean[5]); n_b = $signed({3'b0, r_dt}); end
            OP_M_YAW:   begin n_a = 33'(r_mean[6]); n_b = $signed({3'b0, r_dt}); end
            OP_M_G1:    begin n_a = GRAVITY_Q;      n_b = r_cp;                  end
            OP_M_G2:    begin n_a = r_g1;           n_b = r_cr;                  end
            OP_M_V1:    begin n_a = 33'(r_vel);     n_b = $signed({3'b0, r_decay}); end
            OP_M_V2:    begin n_a = 33'(r_diff);    n_b = $signed({3'b0, r_dt}); end
            OP_M_DT2: begin
                n_a = $signed({17'd0, r_dt});
                n_b = $signed({3'b0, r_dt});
            end
            OP_M_P1: begin n_a = 33'(r_diff); n_b = $signed({3'b0, r_dt2[15:0]});  end
            OP_M_P2: begin n_a = 33'(r_diff); n_b = $signed({3'b0, r_dt2[31:16]}); end
            OP_M_P3: begin n_a = 33'(r_vel);  n_b = $signed({3'b0, r_dt});        end
            default: begin n_a = '0; n_b = '0; end
        endcase
    end

    assign n_p72 = 72'(r_prod);

    always_comb begin
        n_out = '0;
        for (int c = 0; c < NCH; c++) begin
            n_out[c*SB +: SB] = r_mean[c];
        end
        n_out[ROW_W +: ACC_W]           = r_roll;
        n_out[ROW_W + ACC_W +: ACC_W]   = r_pitch;
        n_out[ROW_W + 2*ACC_W +: ACC_W] = r_yaw;
        n_out[ROW_W + 3*ACC_W +: ACC_W] = r_vel;
        n_out[ROW_W + 4*ACC_W +: ACC_W] = r_pos;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_a * n_b;
        if (i_cmd.op == OP_PUBLISH && !n_busy) r_out <= n_out;

        // divider, one quotient bit a cycle, channel after channel
        if (i_cmd.op == OP_DIV) begin
            if (r_dbit == '0) begin
                r_dneg <= r_sum[r_dch][SUM_W-1];
                r_dq   <= r_sum[r_dch][SUM_W-1] ? SUM_W'(-r_sum[r_dch])
                                                : SUM_W'(r_sum[r_dch]);
                r_rem  <= '0;
            end else begin
                r_dq  <= n_dq;
                r_rem <= n_dge ? CNT_W'(n_dt - {1'b0, r_fill}) : CNT_W'(n_dt);
                if (r_dbit == DBIT_W'(SUM_W)) begin
                    r_mean[r_dch] <= r_dneg ? SB'(-n_dq) : SB'(n_dq);
                end
            end
        end

        if (n_cos_op) begin
            if (r_ccnt == 5'd0) begin
                r_aneg <= n_ang[31];
                r_red  <= n_ang[31] ? 32'(-n_ang) : 32'(n_ang);
            end else if (r_ccnt <= 5'd14) begin
                if ({1'b0, r_red} >= n_cmp) r_red <= r_red - n_cmp[31:0];
            end else if (r_ccnt == 5'd15) begin
                r_cneg <= (n_f0 > HALF_PI_Q);
                r_z    <= $signed({5'd0, n_f1});
                r_x    <= CORDIC_X0;
                r_y    <= '0;
            end else begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                if (r_ccnt == 5'd31) begin
                    if (i_cmd.op == OP_COS_P) r_cp <= n_cos;
                    else r_cr <= n_cos;
                end
            end
        end

        case (i_cmd.op)
            OP_A_G1:  r_g1 <= 33'(rnd72(n_p72, 16));
            OP_A_G2:  r_diff <= sat32((72'(r_mean[2]) <<< 8) - rnd72(n_p72, 16));
            OP_A_V1:  r_vtmp <= 40'(rnd72(n_p72, 16));
            OP_A_DT2: r_dt2 <= r_prod[31:0];
            OP_A_P1:  r_pa <= 68'(r_prod);
            OP_A_P2:  r_pa <= r_pa + (68'(r_prod) <<< 16);
            default:  r_pa <= r_pa;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_slot   <= '0;
            r_dt     <= TIME_STEP_RST;
            r_decay  <= DECAY_RST;
            r_roll   <= '0;
            r_pitch  <= '0;
            r_yaw    <= '0;
            r_vel    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
            r_dch    <= '0;
            r_dbit   <= '0;
            r_ccnt   <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TIME_STEP: r_dt    <= i_cfg_data;
                    CFG_DECAY:     r_decay <= i_cfg_data;
                    default:       r_dt    <= r_dt;
                endcase
            end

            if (i_cmd.op == OP_SUMS) begin
                for (int c = 0; c < NCH; c++) begin
                    r_sum[c] <= r_sum[c]
                        - (n_full ? SUM_W'($signed(r_old[c*SB +: SB])) : SUM_W'(0))
                        + SUM_W'($signed(r_in[c*SB +: SB]));
                end
                if (!n_full) r_fill <= r_fill + CNT_W'(1);
                r_slot <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
            end

            if (i_cmd.op == OP_DIV) begin
                if (r_dbit == DBIT_W'(SUM_W)) begin
                    r_dbit <= '0;
                    r_dch  <= r_dch + 3'd1;
                end else begin
                    r_dbit <= r_dbit + DBIT_W'(1);
                end
            end else begin
                r_dbit <= '0;
                r_dch  <= '0;
            end

            r_ccnt <= n_cos_op ? r_ccnt + 5'd1 : 5'd0;

            case (i_cmd.op)
                OP_A_ROLL:  r_roll  <= sat32(72'(r_roll) + rnd72(n_p72, 8));
                OP_A_PITCH: r_pitch <= sat32(72'(r_pitch) + rnd72(n_p72, 8));
                OP_A_YAW:   r_yaw   <= sat32(72'(r_yaw) + rnd72(n_p72, 8));
                OP_A_V2:    r_vel   <= sat32(72'(r_vtmp) + rnd72(n_p72, 16));
                OP_A_P3: begin
                    r_pos <= sat32(72'(r_pos) + rnd72(72'(r_pa), 33) + rnd72(n_p72, 16));
                end
                default: r_pos <= r_pos;
            endcase

            if (i_cmd.op == OP_PUBLISH && !n_busy) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.div_done = n_div_last;
    assign o_stat.cos_done = n_cos_op && (r_ccnt == 5'd31);
    assign o_stat.out_busy = n_busy;
    assign o_m_tvalid      = r_ovalid;
    assign o_m_tdata       = r_out;

    `IMWT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(WINDOW))
    `IMWT_ASSERT_NXT(a_fill_grows, i_clk, i_rst_n,
        i_cmd.op == OP_SUMS && !n_full, r_fill == $past(r_fill) + CNT_W'(1))
    `IMWT_ASSERT_NXT(a_publish_loads, i_clk, i_rst_n,
        i_cmd.op == OP_PUBLISH && !n_busy, r_ovalid)

endmodule

[rtl/imu_window_mean_tilt_integrator_core.sv]
// Top level of the windowed-mean IMU tilt and vertical integrator.
// Instantiates imwt_ctrl and imwt_dp; uses imwt_pkg.
//
// Usage. One seven-channel IMU sample arrives as a beat on the slave
// stream (i_s_*), and one result beat leaves on the master stream (o_m_*)
// for every sample taken. Each result carries the windowed channel means,
// the integrated roll, pitch and yaw, and the vertical velocity and position.
// Two configuration registers (time step, velocity decay) are written over
// the plain write port while the block is idle.
// Structure. The bit-serial divider that forms the seven means works on
// sums of SUM_W = SAMPLE_BITS + clog2(WINDOW) bits and dominates the run,
// followed by the two CORDIC runs for the cosines; the single shared
// multiplier takes the remaining steps. One sample is in flight at a time:
// the sequencer takes the next only from its idle state, once the result
// of the last one has been loaded into the output register.
// Reset clears the sums, fill count, accumulators and output valid, and
// restores the register defaults. The result sits in an output register; a
// new sample is accepted while it waits, and the next result is held back
// only until the receiver takes the previous beat.
`timescale 1ns / 1ps
module imu_window_mean_tilt_integrator_core
    import imwt_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_W        = ((NCH * SAMPLE_BITS + 7) / 8) * 8,
    parameter int OUT_W       = ((NCH * SAMPLE_BITS + 5 * ACC_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // accel_x, accel_y, accel_z, temperature, rate_x, rate_y, rate_z; zero padded
    input  logic [IN_W-1:0]      i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // mean_accel_x, mean_accel_y, mean_accel_z, mean_temperature, mean_rate_x,
    // mean_rate_y, mean_rate_z, roll_angle, pitch_angle, yaw_angle,
    // vertical_velocity, vertical_position; zero padded
    output logic [OUT_W-1:0]     o_m_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    imwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    imwt_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
